[hdl/gdo_pkg.sv]
// shared types, constants and tables for the date offset pipeline
package gdo_pkg;

  localparam int JDN_W = 27;
  localparam int A_W   = 26;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_YEAR  = 3'd1;
  localparam logic [2:0] ST_BAD_MONTH = 3'd2;
  localparam logic [2:0] ST_BAD_DAY   = 3'd3;
  localparam logic [2:0] ST_RANGE     = 3'd4;

  localparam int JDN_BIAS  = 32045;
  localparam int JDN_SHIFT = 32044;
  localparam int JDN_LO    = 1721426;
  localparam int YEAR_BIAS = 4800;

  // reciprocals for exact division by constants
  localparam logic [14:0] R100  = 15'((64'd1 << 21) / 64'd100 + 64'd1);
  localparam logic [28:0] R146  = 29'(((64'd1 << 46) + 64'd146096) / 64'd146097);
  localparam logic [20:0] R1461 = 21'(((64'd1 << 31) + 64'd1460) / 64'd1461);
  localparam logic [11:0] R153  = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

  typedef struct packed {
    logic                    vld;
    logic [2:0]              status;
    logic signed [JDN_W-1:0] jdn0;
    logic signed [20:0]      off;
  } conv_t;

  typedef struct packed {
    logic        vld;
    logic [2:0]  status;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic [22:0] day_number;
  } res_t;

  // days before month mm, counted from march
  function automatic logic [8:0] month_base(input logic [3:0] mm);
    logic [8:0] r;
    case (mm)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:    r = leap ? 5'd29 : 5'd28;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

[hdl/gdo_if.sv]
// handshake channels for date words and result words
interface gdo_in_if;
  logic               valid;
  logic               ready;
  logic [13:0]        in_year;
  logic [3:0]         in_month;
  logic [4:0]         in_day;
  logic signed [20:0] day_offset;
  modport source (output valid, in_year, in_month, in_day, day_offset, input ready);
  modport sink (input valid, in_year, in_month, in_day, day_offset, output ready);
endinterface

interface gdo_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [13:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [2:0]  weekday;
  logic [22:0] day_number;
  modport source (output valid, status, out_year, out_month, out_day, weekday, day_number,
                  input ready);
  modport sink (input valid, status, out_year, out_month, out_day, weekday, day_number,
                output ready);
endinterface

[hdl/gdo_to_jdn.sv]
// date check and date to day number, two stages
module gdo_to_jdn import gdo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_vld,
  input  logic [13:0]        in_year,
  input  logic [3:0]         in_month,
  input  logic [4:0]         in_day,
  input  logic signed [20:0] day_offset,
  output conv_t              conv
);

  logic               s1_vld;
  logic [13:0]        s1_y;
  logic [3:0]         s1_m;
  logic [4:0]         s1_d;
  logic signed [20:0] s1_off;
  logic [14:0]        s1_yy;
  logic [3:0]         s1_mm;
  logic [7:0]         s1_y100;
  logic [8:0]         s1_yy100;
  logic [6:0]         s1_yy400;

  logic        early;
  logic [14:0] yy;
  logic [28:0] py;
  logic [29:0] pyy;
  logic [27:0] pyy4;

  assign early = (in_month < 4'd3);
  assign yy    = 15'(in_year) + 15'(YEAR_BIAS) - 15'(early);
  assign py    = 29'(in_year) * 29'(R100);
  assign pyy   = 30'(yy) * 30'(R100);
  assign pyy4  = 28'(yy[14:2]) * 28'(R100);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= in_vld;
    end
    if (adv) begin
      s1_y     <= in_year;
      s1_m     <= in_month;
      s1_d     <= in_day;
      s1_off   <= day_offset;
      s1_yy    <= yy;
      s1_mm    <= in_month + (early ? 4'd12 : 4'd0) - 4'd3;
      s1_y100  <= py[28:21];
      s1_yy100 <= pyy[29:21];
      s1_yy400 <= pyy4[27:21];
    end
  end

  logic                    leap;
  logic [14:0]             cent;
  logic [4:0]              mdays;
  logic [2:0]              status;
  logic signed [JDN_W-1:0] jdn0;

  assign cent  = 15'(s1_y100) * 15'd100;
  assign leap  = (s1_y[1:0] == 2'd0) && ((15'(s1_y) != cent) || (s1_y100[1:0] == 2'd0));
  assign mdays = month_len(s1_m, leap);
  assign jdn0  = JDN_W'(s1_d) + JDN_W'(month_base(s1_mm)) + JDN_W'(s1_yy) * JDN_W'(365)
               + JDN_W'(s1_yy[14:2]) - JDN_W'(s1_yy100) + JDN_W'(s1_yy400)
               - JDN_W'(JDN_BIAS);

  always_comb begin
    if (s1_y == 14'd0) begin
      status = ST_BAD_YEAR;
    end else if (s1_m == 4'd0 || s1_m > 4'd12) begin
      status = ST_BAD_MONTH;
    end else if (s1_d == 5'd0 || s1_d > mdays) begin
      status = ST_BAD_DAY;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      conv.vld <= 1'b0;
    end else if (adv) begin
      conv.vld <= s1_vld;
    end
    if (adv) begin
      conv.status <= status;
      conv.jdn0   <= jdn0;
      conv.off    <= s1_off;
    end
  end

endmodule

[hdl/gdo_from_jdn.sv]
// offset add, range check, day number to date and weekday
module gdo_from_jdn import gdo_pkg::*; #(
  parameter int MAX_YEAR = 9999
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  conv_t conv,
  output res_t  res
);

  localparam int HI_YY  = MAX_YEAR + YEAR_BIAS;
  localparam int JDN_HI = 31 + 275 + 365 * HI_YY + HI_YY / 4 - HI_YY / 100 + HI_YY / 400
                        - JDN_BIAS;

  // stage 3: add offset
  logic                    s3_vld;
  logic [2:0]              s3_st;
  logic signed [JDN_W-1:0] s3_jdn;

  // stage 4: range check
  logic                    s4_vld;
  logic [2:0]              s4_st;
  logic signed [JDN_W-1:0] s4_jdn;
  logic [A_W-1:0]          s4_a;

  // stage 5: centuries
  logic                    s5_vld;
  logic [2:0]              s5_st;
  logic [22:0]             s5_jdn;
  logic [A_W-1:0]          s5_a;
  logic [9:0]              s5_b;
  logic [5:0]              s5_ws;

  // stage 6: day in century, weekday
  logic                    s6_vld;
  logic [2:0]              s6_st;
  logic [22:0]             s6_jdn;
  logic [9:0]              s6_b;
  logic [17:0]             s6_c;
  logic [2:0]              s6_wd;

  // stage 7: years in century
  logic                    s7_vld;
  logic [2:0]              s7_st;
  logic [22:0]             s7_jdn;
  logic [9:0]              s7_b;
  logic [17:0]             s7_c;
  logic [6:0]              s7_dd;
  logic [2:0]              s7_wd;

  // stage 8: day in year
  logic                    s8_vld;
  logic [2:0]              s8_st;
  logic [22:0]             s8_jdn;
  logic [9:0]              s8_b;
  logic [6:0]              s8_dd;
  logic [8:0]              s8_e;
  logic [2:0]              s8_wd;

  // stage 9: month
  logic                    s9_vld;
  logic [2:0]              s9_st;
  logic [22:0]             s9_jdn;
  logic [9:0]              s9_b;
  logic [6:0]              s9_dd;
  logic [8:0]              s9_e;
  logic [3:0]              s9_mm;
  logic [2:0]              s9_wd;

  logic [2:0]     st4;
  logic [A_W+1:0] num_b;
  logic [56:0]    pb;
  logic [A_W:0]   jp1;
  logic [5:0]     ws;
  logic [27:0]    pc;
  logic [3:0]     w1;
  logic [3:0]     w2;
  logic [2:0]     wd;
  logic [19:0]    num_dd;
  logic [40:0]    pdd;
  logic [17:0]    pe;
  logic [10:0]    num_mm;
  logic [22:0]    pmm;
  logic [16:0]    yr;
  logic [4:0]     dy;
  logic [3:0]     mo;

  always_comb begin
    st4 = s3_st;
    if (s3_st == ST_OK && (s3_jdn < JDN_W'(JDN_LO) || s3_jdn > JDN_W'(JDN_HI))) begin
      st4 = ST_RANGE;
    end
  end

  assign num_b = {s4_a, 2'b11};
  assign pb    = 57'(num_b) * 57'(R146);
  assign jp1   = (A_W+1)'(s4_jdn) + (A_W+1)'(1);

  // octal digit sum, since 8 is 1 mod 7
  always_comb begin
    ws = 6'd0;
    for (int i = 0; i < 9; i++) begin
      ws = ws + 6'((jp1 >> (3 * i)) & (A_W+1)'(7));
    end
  end

  assign pc = 28'(s5_b) * 28'd146097;
  assign w1 = 4'(s5_ws[5:3]) + 4'(s5_ws[2:0]);
  assign w2 = (w1 >= 4'd7) ? w1 - 4'd7 : w1;
  assign wd = (w2 >= 4'd7) ? 3'(w2 - 4'd7) : w2[2:0];

  assign num_dd = {s6_c, 2'b11};
  assign pdd    = 41'(num_dd) * 41'(R1461);
  assign pe     = 18'(s7_dd) * 18'd1461;

  assign num_mm = 11'(s8_e) * 11'd5 + 11'd2;
  assign pmm    = 23'(num_mm) * 23'(R153);

  assign dy = 5'(s9_e - month_base(s9_mm) + 9'd1);
  assign mo = (s9_mm < 4'd10) ? s9_mm + 4'd3 : s9_mm - 4'd9;
  assign yr = 17'(s9_b) * 17'd100 + 17'(s9_dd) - 17'(YEAR_BIAS)
            + 17'(s9_mm >= 4'd10);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld  <= 1'b0;
      s4_vld  <= 1'b0;
      s5_vld  <= 1'b0;
      s6_vld  <= 1'b0;
      s7_vld  <= 1'b0;
      s8_vld  <= 1'b0;
      s9_vld  <= 1'b0;
      res.vld <= 1'b0;
    end else if (adv) begin
      s3_vld  <= conv.vld;
      s4_vld  <= s3_vld;
      s5_vld  <= s4_vld;
      s6_vld  <= s5_vld;
      s7_vld  <= s6_vld;
      s8_vld  <= s7_vld;
      s9_vld  <= s8_vld;
      res.vld <= s9_vld;
    end
    if (adv) begin
      s3_st  <= conv.status;
      s3_jdn <= conv.jdn0 + JDN_W'(conv.off);

      s4_st  <= st4;
      s4_jdn <= s3_jdn;
      s4_a   <= A_W'(s3_jdn + JDN_W'(JDN_SHIFT));

      s5_st  <= s4_st;
      s5_jdn <= s4_jdn[22:0];
      s5_a   <= s4_a;
      s5_b   <= pb[55:46];
      s5_ws  <= ws;

      s6_st  <= s5_st;
      s6_jdn <= s5_jdn;
      s6_b   <= s5_b;
      s6_c   <= 18'(s5_a - A_W'(pc[27:2]));
      s6_wd  <= wd;

      s7_st  <= s6_st;
      s7_jdn <= s6_jdn;
      s7_b   <= s6_b;
      s7_c   <= s6_c;
      s7_dd  <= pdd[37:31];
      s7_wd  <= s6_wd;

      s8_st  <= s7_st;
      s8_jdn <= s7_jdn;
      s8_b   <= s7_b;
      s8_dd  <= s7_dd;
      s8_e   <= 9'(s7_c - pe[17:2]);
      s8_wd  <= s7_wd;

      s9_st  <= s8_st;
      s9_jdn <= s8_jdn;
      s9_b   <= s8_b;
      s9_dd  <= s8_dd;
      s9_e   <= s8_e;
      s9_mm  <= pmm[22:19];
      s9_wd  <= s8_wd;

      res.status <= s9_st;
      if (s9_st == ST_OK) begin
        res.year       <= yr[13:0];
        res.month      <= mo;
        res.day        <= dy;
        res.weekday    <= s9_wd;
        res.day_number <= s9_jdn;
      end else begin
        res.year       <= 14'd0;
        res.month      <= 4'd0;
        res.day        <= 5'd0;
        res.weekday    <= 3'd0;
        res.day_number <= 23'd0;
      end
    end
  end

endmodule

[hdl/gregorian_date_offset_calc_top.sv]
// top level of the gregorian date offset calculator
//
//  channel  dir  word
//  din      in   in_year, in_month, in_day, day_offset
//  dout     out  status, out_year, out_month, out_day, weekday, day_number
//
//  one word per cycle while dout is not stalled
//  each word passes through the ten register stages of the convert chain
//  rst is synchronous and clears only the stage valid bits
//  a stall on dout holds every stage; din.ready follows it
module gregorian_date_offset_calc_top import gdo_pkg::*; #(
  parameter int MAX_YEAR = 9999
) (
  input  logic       clk,
  input  logic       rst,
  gdo_in_if.sink     din,
  gdo_out_if.source  dout
);

  logic  adv;
  conv_t conv;
  res_t  res;

  assign adv       = !res.vld || dout.ready;
  assign din.ready = adv;

  gdo_to_jdn u_to_jdn (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_vld     (din.valid),
    .in_year    (din.in_year),
    .in_month   (din.in_month),
    .in_day     (din.in_day),
    .day_offset (din.day_offset),
    .conv       (conv)
  );

  gdo_from_jdn #(
    .MAX_YEAR (MAX_YEAR)
  ) u_from_jdn (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .conv (conv),
    .res  (res)
  );

  assign dout.valid      = res.vld;
  assign dout.status     = res.status;
  assign dout.out_year   = res.year;
  assign dout.out_month  = res.month;
  assign dout.out_day    = res.day;
  assign dout.weekday    = res.weekday;
  assign dout.day_number = res.day_number;

endmodule
